// ===== sv/stream_cipher_keystream_xor_core_macros.svh =====
// assertion macros for the keystream xor core
// no dependencies
`ifndef STREAM_CIPHER_KEYSTREAM_XOR_CORE_MACROS_SVH
`define STREAM_CIPHER_KEYSTREAM_XOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SCK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SCK_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SCK_ASSERT(label, clk, rst, prop)
`define SCK_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/sck_pkg.sv =====
// shared types, constants and functions for the keystream xor core
// no dependencies
package sck_pkg;
   localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
   localparam logic [31:0] TRANS_MUL = 32'h54655307;
   localparam logic [31:0] ALPHA_HI  = 32'hA9000000;
   localparam logic [31:0] ALPHA_LO  = 32'h000000A9;
   localparam logic [31:0] PAD_WORD  = 32'h80000000;

   localparam logic [1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [1:0] REG_KEY_LOW  = 2'd1;
   localparam logic [1:0] REG_IV_HIGH  = 2'd2;
   localparam logic [1:0] REG_IV_LOW   = 2'd3;

   typedef logic [3:0][31:0] quad_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP_LOAD, ST_KEY_EXP, ST_SUBKEY, ST_ROUND_XOR, ST_ROUND_SBOX,
      ST_ROUND_MIX, ST_SETUP_END, ST_GEN_CHECK, ST_GEN_STEP, ST_GEN_MUL, ST_GEN_DONE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic setup_load;
      logic key_exp;
      logic subkey;
      logic round_xor;
      logic round_sbox;
      logic round_mix;
      logic setup_end;
      logic gen_start;
      logic gen_step;
      logic gen_mul;
      logic gen_done;
      logic gen_zero;
   } cmd_type;

   typedef struct packed {
      logic lfsr_live;
   } status_type;

   function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [3:0] idx);
      logic [3:0] t [8][16];
      t[0] = '{3,8,15,1,10,6,5,11,14,13,4,2,7,0,9,12};
      t[1] = '{15,12,2,7,9,0,5,10,1,11,14,8,6,13,3,4};
      t[2] = '{8,6,7,9,3,12,10,15,13,1,14,4,0,11,5,2};
      t[3] = '{0,15,11,8,12,9,6,3,13,1,2,4,10,7,5,14};
      t[4] = '{1,15,8,3,12,0,11,6,2,5,4,10,9,14,7,13};
      t[5] = '{15,5,2,11,4,10,9,12,0,3,14,8,13,6,7,1};
      t[6] = '{7,2,12,5,8,4,6,11,14,9,1,15,13,3,10,0};
      t[7] = '{1,13,15,0,14,8,2,11,7,4,12,10,9,3,5,6};
      return t[box][idx];
   endfunction

   function automatic quad_type sbox_apply(input logic [2:0] box, input quad_type x);
      quad_type y;
      logic [3:0] o;
      for (int b = 0; b < 32; b++) begin
         o = sbox_lookup(box, {x[3][b], x[2][b], x[1][b], x[0][b]});
         y[0][b] = o[0];
         y[1][b] = o[1];
         y[2][b] = o[2];
         y[3][b] = o[3];
      end
      return y;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction
endpackage

// ===== sv/stream_cipher_keystream_xor_core.sv =====
// top level of the byte-serial keystream xor core
// depends on sck_pkg, sck_ctrl, sck_datapath
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata[7:0] data_byte, tuser restart
// rsp      out  rsp_tvalid/rsp_tready  tdata[7:0] result_byte
// csr      in   csr_we                 csr_index selects register, csr_data 64 bits
//
// plain byte: goes from idle straight to output; the first byte of a block first runs four lfsr/fsm
// steps, each split across the 32x32 multiply register (skipped, keystream zeroed, when lfsr is zero)
// restart runs setup before that: 100 key schedule steps and 24 serial rounds
// the result sits in an output register; the next item is taken while it waits
// synchronous active-high reset clears lfsr, fsm, keystream and position to zero
module stream_cipher_keystream_xor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // result_byte
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import sck_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       take_item;
   logic [3:0] byte_pos;
   // a result is written when the controller leaves its output state
   logic       emit;

   sck_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .byte_pos    (byte_pos),
      .status      (status),
      .cmd         (cmd),
      .take_item   (take_item),
      .emit        (emit)
   );

   sck_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .take_item       (take_item),
      .req_data_byte   (req_tdata),
      .req_restart     (req_tuser),
      .emit            (emit),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .byte_pos        (byte_pos),
      .rsp_result_byte (rsp_tdata)
   );
endmodule

// ===== sv/sck_ctrl.sv =====
// sequencer for setup, block generation and byte output
// depends on sck_pkg
module sck_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_restart,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [3:0]          byte_pos,
   input  sck_pkg::status_type status,
   output sck_pkg::cmd_type    cmd,
   output logic                take_item,
   output logic                emit
);
   import sck_pkg::*;

   state_type  state_ff, state_in;
   logic [4:0] group_ff, group_in;
   logic [1:0] sub_ff, sub_in;

   // holds a result while the next item may wait in setup or generation
   logic out_full_ff, out_full_in;

   assign rsp_tvalid = out_full_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign take_item  = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      group_in = group_ff;
      sub_in   = sub_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_item) begin
               if (req_restart) begin
                  state_in = ST_SETUP_LOAD;
               end else if (byte_pos == 4'd0) begin
                  state_in = ST_GEN_CHECK;
               end else begin
                  state_in = ST_OUTPUT;
               end
            end
         end
         ST_SETUP_LOAD: begin
            state_in = ST_KEY_EXP;
            group_in = 5'd0;
            sub_in   = 2'd0;
         end
         ST_KEY_EXP: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd3) begin
               state_in = ST_SUBKEY;
            end
         end
         ST_SUBKEY:  state_in = ST_ROUND_XOR;
         ST_ROUND_XOR: begin
            state_in = (group_ff == 5'd24) ? ST_SETUP_END : ST_ROUND_SBOX;
         end
         ST_ROUND_SBOX: begin
            if (group_ff == 5'd23) begin
               state_in = ST_KEY_EXP;
               group_in = group_ff + 5'd1;
            end else begin
               state_in = ST_ROUND_MIX;
            end
         end
         ST_ROUND_MIX: begin
            state_in = ST_KEY_EXP;
            group_in = group_ff + 5'd1;
         end
         ST_SETUP_END: state_in = ST_GEN_CHECK;
         ST_GEN_CHECK: begin
            sub_in   = 2'd0;
            state_in = status.lfsr_live ? ST_GEN_STEP : ST_OUTPUT;
         end
         ST_GEN_STEP: state_in = ST_GEN_MUL;
         ST_GEN_MUL: begin
            sub_in   = sub_ff + 2'd1;
            state_in = (sub_ff == 2'd3) ? ST_GEN_DONE : ST_GEN_STEP;
         end
         ST_GEN_DONE: state_in = ST_OUTPUT;
         ST_OUTPUT: begin
            if (!out_full_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_SETUP_LOAD: cmd.setup_load = 1'b1;
         ST_KEY_EXP:    cmd.key_exp    = 1'b1;
         ST_SUBKEY:     cmd.subkey     = 1'b1;
         ST_ROUND_XOR:  cmd.round_xor  = 1'b1;
         ST_ROUND_SBOX: cmd.round_sbox = 1'b1;
         ST_ROUND_MIX:  cmd.round_mix  = 1'b1;
         ST_SETUP_END:  cmd.setup_end  = 1'b1;
         ST_GEN_CHECK: begin
            cmd.gen_start = status.lfsr_live;
            cmd.gen_zero  = !status.lfsr_live;
         end
         ST_GEN_STEP:   cmd.gen_step   = 1'b1;
         ST_GEN_MUL:    cmd.gen_mul    = 1'b1;
         ST_GEN_DONE:   cmd.gen_done   = 1'b1;
         default:       cmd = '0;
      endcase
   end

   // result written only when the output register is free or draining
   assign emit = (state_ff == ST_OUTPUT) && (!out_full_ff || rsp_tready);

   always_comb begin
      out_full_in = out_full_ff;
      if (rsp_tready) begin
         out_full_in = 1'b0;
      end
      if (emit) begin
         out_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         group_ff    <= '0;
         sub_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         group_ff    <= group_in;
         sub_ff      <= sub_in;
         out_full_ff <= out_full_in;
      end
   end

`include "stream_cipher_keystream_xor_core_macros.svh"
   `SCK_ASSERT(a_ready_idle, clock, reset, req_tready |-> (state_ff == ST_IDLE))
   `SCK_ASSERT(a_group_range, clock, reset, (group_ff <= 5'd24))
   `SCK_ASSERT(a_out_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
endmodule

// ===== sv/sck_datapath.sv =====
// key schedule, serpent rounds, lfsr and fsm, keystream xor
// depends on sck_pkg
module sck_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sck_pkg::cmd_type cmd,
   output sck_pkg::status_type status,
   input  logic             take_item,
   input  logic [7:0]       req_data_byte,
   input  logic             req_restart,
   input  logic             emit,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data,
   output logic [3:0]       byte_pos,
   output logic [7:0]       rsp_result_byte
);
   import sck_pkg::*;

   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [31:0] lfsr_ff [10];
   logic [31:0] lfsr_in [10];
   logic [31:0] fsm1_ff, fsm1_in, fsm2_ff, fsm2_in;
   quad_type    ks_ff, ks_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   quad_type    blk_ff, blk_in, sk_ff, sk_in, s0_ff, s0_in, f_ff, f_in;
   logic [4:0]  grp_ff, grp_in;
   logic [1:0]  k_ff, k_in;
   logic [31:0] prod_ff, prod_in;
   logic [7:0]  data_ff, res_ff, res_in;
   logic        live;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_data;
            REG_KEY_LOW:  key_low_ff  <= csr_data;
            REG_IV_HIGH:  iv_high_ff  <= csr_data;
            REG_IV_LOW:   iv_low_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      live = 1'b0;
      for (int i = 0; i < 10; i++) begin
         live = live | (lfsr_ff[i] != '0);
      end
   end
   assign status.lfsr_live = live;

   always_comb begin
      logic [31:0] t, mux, a, d;
      quad_type    y;
      logic [6:0]  cnt;
      t   = '0;
      mux = '0;
      a   = '0;
      d   = '0;
      y   = '0;
      cnt = '0;
      lfsr_in = lfsr_ff;
      fsm1_in = fsm1_ff;
      fsm2_in = fsm2_ff;
      ks_in   = ks_ff;
      pos_in  = pos_ff;
      win_in  = win_ff;
      blk_in  = blk_ff;
      sk_in   = sk_ff;
      s0_in   = s0_ff;
      f_in    = f_ff;
      grp_in  = grp_ff;
      k_in    = k_ff;
      prod_in = prod_ff;
      res_in  = res_ff;
      if (cmd.setup_load) begin
         win_in[0] = key_high_ff[63:32];
         win_in[1] = key_high_ff[31:0];
         win_in[2] = key_low_ff[63:32];
         win_in[3] = key_low_ff[31:0];
         win_in[4] = PAD_WORD;
         win_in[5] = '0;
         win_in[6] = '0;
         win_in[7] = '0;
         blk_in = {iv_low_ff[31:0], iv_low_ff[63:32], iv_high_ff[31:0], iv_high_ff[63:32]};
         grp_in = '0;
         k_in   = '0;
      end
      if (cmd.key_exp) begin
         cnt = {grp_ff, k_ff};
         t = win_ff[0] ^ win_ff[3] ^ win_ff[5] ^ win_ff[7] ^ GOLDEN ^ {25'd0, cnt};
         for (int i = 0; i < 7; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[7] = rotl(t, 11);
         k_in = k_ff + 2'd1;
      end
      if (cmd.subkey) begin
         y = {win_ff[7], win_ff[6], win_ff[5], win_ff[4]};
         sk_in = sbox_apply(3'(5'd3 - grp_ff), y);
      end
      if (cmd.round_xor) begin
         blk_in = blk_ff ^ sk_ff;
         if (grp_ff == 5'd24) begin
            blk_in = blk_ff ^ sk_ff;
         end
      end
      if (cmd.round_sbox) begin
         blk_in = sbox_apply(grp_ff[2:0], blk_ff);
         if (grp_ff == 5'd11) begin
            lfsr_in[7] = blk_in[0];
            lfsr_in[8] = blk_in[1];
            lfsr_in[9] = blk_in[2];
            lfsr_in[0] = blk_in[3];
         end else if (grp_ff == 5'd17) begin
            lfsr_in[1] = blk_in[0];
            lfsr_in[2] = blk_in[1];
            lfsr_in[3] = blk_in[2];
            lfsr_in[4] = blk_in[3];
         end
         if (grp_ff == 5'd23) begin
            grp_in = grp_ff + 5'd1;
         end
      end
      if (cmd.round_mix) begin
         y = blk_ff;
         y[0] = rotl(y[0], 13);
         y[2] = rotl(y[2], 3);
         y[1] = y[1] ^ y[0] ^ y[2];
         y[3] = y[3] ^ y[2] ^ (y[0] << 3);
         y[1] = rotl(y[1], 1);
         y[3] = rotl(y[3], 7);
         y[0] = y[0] ^ y[1] ^ y[3];
         y[2] = y[2] ^ y[3] ^ (y[1] << 7);
         y[0] = rotl(y[0], 5);
         y[2] = rotl(y[2], 22);
         blk_in = y;
         grp_in = grp_ff + 5'd1;
      end
      if (cmd.setup_end) begin
         lfsr_in[5] = blk_ff[0];
         lfsr_in[6] = blk_ff[1];
         fsm1_in    = blk_ff[2];
         fsm2_in    = blk_ff[3];
      end
      if (cmd.gen_start) begin
         s0_in = {lfsr_ff[3], lfsr_ff[2], lfsr_ff[1], lfsr_ff[0]};
         k_in  = '0;
      end
      if (cmd.gen_zero) begin
         ks_in = '0;
      end
      if (cmd.gen_step) begin
         f_in[k_ff] = (lfsr_ff[9] + fsm1_ff) ^ fsm2_ff;
         mux = fsm1_ff[0] ? (lfsr_ff[1] ^ lfsr_ff[8]) : lfsr_ff[1];
         prod_in = fsm1_ff * TRANS_MUL;
         fsm1_in = fsm2_ff + mux;
         a = (lfsr_ff[0] << 8) ^ ((lfsr_ff[0][31:24] != 8'd0) ? ALPHA_HI : 32'd0);
         d = (lfsr_ff[3] >> 8) ^ ((lfsr_ff[3][7:0] != 8'd0) ? ALPHA_LO : 32'd0);
         for (int i = 0; i < 9; i++) begin
            lfsr_in[i] = lfsr_ff[i+1];
         end
         lfsr_in[9] = lfsr_ff[9] ^ d ^ a;
      end
      if (cmd.gen_mul) begin
         fsm2_in = rotl(prod_ff, 7);
         k_in    = k_ff + 2'd1;
      end
      if (cmd.gen_done) begin
         y[0] = ~f_ff[0];
         y[1] = f_ff[1] ^ f_ff[3];
         y[2] = y[0] ^ y[1];
         y[3] = f_ff[2] ^ y[1];
         t    = y[2] ^ (f_ff[1] & y[3]);
         a    = f_ff[0] ^ (f_ff[3] | t);
         d    = f_ff[2] | a;
         ks_in[0] = (y[2] ^ d) ^ s0_ff[0];
         ks_in[1] = (y[3] ^ a) ^ s0_ff[1];
         ks_in[2] = (t ^ d) ^ s0_ff[2];
         ks_in[3] = d ^ s0_ff[3];
      end
      if (take_item && req_restart) begin
         pos_in = '0;
      end
      if (emit) begin
         res_in = data_ff ^ ks_ff[pos_ff[3:2]][8*pos_ff[1:0] +: 8];
         pos_in = pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 10; i++) begin
            lfsr_ff[i] <= '0;
         end
         fsm1_ff <= '0;
         fsm2_ff <= '0;
         ks_ff   <= '0;
         pos_ff  <= '0;
         grp_ff  <= '0;
         k_ff    <= '0;
      end else begin
         lfsr_ff <= lfsr_in;
         fsm1_ff <= fsm1_in;
         fsm2_ff <= fsm2_in;
         ks_ff   <= ks_in;
         pos_ff  <= pos_in;
         grp_ff  <= grp_in;
         k_ff    <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      blk_ff  <= blk_in;
      sk_ff   <= sk_in;
      s0_ff   <= s0_in;
      f_ff    <= f_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      if (take_item) begin
         data_ff <= req_data_byte;
      end
   end

   assign byte_pos        = pos_in;
   assign rsp_result_byte = res_ff;

`include "stream_cipher_keystream_xor_core_macros.svh"
   `SCK_ASSERT(a_zero_keeps, clock, reset, cmd.gen_zero |=> (ks_ff == '0))
   `SCK_ASSERT(a_emit_steps, clock, reset, emit |=> (pos_ff == $past(pos_ff) + 4'd1))
   `SCK_ASSERT(a_one_cmd, clock, reset, $onehot0({cmd.gen_step, cmd.gen_mul, cmd.key_exp}))
endmodule
